/* hdl/lz_window_byte_decoder_macros.svh */
// Assertion macros shared by the window byte decoder RTL.
// Defining NO_ASSERTIONS turns every macro into an empty body.
// The macros expect signals named clk and rst_n in the scope of use.
`ifndef LZ_WINDOW_BYTE_DECODER_MACROS_SVH
`define LZ_WINDOW_BYTE_DECODER_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define LZWBD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lz_window_byte_decoder: same-cycle check failed");
// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define LZWBD_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lz_window_byte_decoder: next-cycle check failed");
`else
`define LZWBD_ASSERT_IMP(label, ante, cons)
`define LZWBD_ASSERT_NXT(label, ante, cons)
`endif

`endif

/* hdl/lzwbd_pkg.sv */
// Shared types and constants of the window byte decoder.
// No dependencies; imported by the controller, datapath and top level.
package lzwbd_pkg;

  localparam int WIN_AW  = 12;
  localparam int HDR_W   = 5;
  localparam int LEN_W   = 32;
  localparam int RUN_W   = 9;
  localparam int WORD_W  = 64;
  localparam int CNT_W   = 4;

  // Token parser phases.
  localparam logic [1:0] PH_TOKEN   = 2'd0;
  localparam logic [1:0] PH_DIST_LO = 2'd1;
  localparam logic [1:0] PH_EXTRA   = 2'd2;

  // Controller to datapath.
  typedef struct packed {
    logic take;   // accept the input byte and update the parser
    logic put;    // write one decoded byte this cycle
    logic lit;    // the byte written is the held literal
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic act_lit;    // the input byte decodes to a literal
    logic act_copy;   // the input byte completes a back-reference
    logic copy_last;  // one copy byte remains
    logic pack_room;  // the packing word takes another byte without emitting
    logic out_free;   // the output register can load this cycle
  } sts_t;

endpackage

/* hdl/lzwbd_ctrl.sv */
// Sequencing state machine of the window byte decoder.
// Depends on lzwbd_pkg for the command and status structs.
module lzwbd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  lzwbd_pkg::sts_t   sts,
  output lzwbd_pkg::cmd_t   cmd
);
  import lzwbd_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LIT  = 2'd1;
  localparam logic [1:0] S_PREP = 2'd2;
  localparam logic [1:0] S_COPY = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
        if (in_valid && sts.act_lit) begin
          state_nxt = S_LIT;
        end else if (in_valid && sts.act_copy) begin
          state_nxt = S_PREP;
        end
      end
      S_LIT: begin
        cmd.lit = 1'b1;
        cmd.put = sts.out_free;
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      // A wait state lets the history read settle on the new distance.
      S_PREP: begin
        state_nxt = S_COPY;
      end
      S_COPY: begin
        cmd.put = sts.out_free || (!sts.copy_last && sts.pack_room);
        if (cmd.put && sts.copy_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* hdl/lzwbd_datapath.sv */
// Datapath of the window byte decoder: parser registers, history memory,
// byte packing and the output register. Depends on lzwbd_pkg.
module lzwbd_datapath #(
  parameter int HEADER_BYTES = 16,
  parameter int LANE_BYTES   = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [lzwbd_pkg::LEN_W-1:0]   cfg_wr_data,
  input  logic [7:0]                    in_byte,
  input  logic                          start_stream,
  input  lzwbd_pkg::cmd_t               cmd,
  output lzwbd_pkg::sts_t               sts,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [lzwbd_pkg::WORD_W-1:0]  out_bytes,
  output logic [lzwbd_pkg::CNT_W-1:0]   byte_count,
  output logic                          out_last,
  output logic                          out_done
);
  import lzwbd_pkg::*;

  localparam int WIN_BYTES = 1 << WIN_AW;
  localparam logic [HDR_W-1:0] HDR_RESET = HDR_W'(HEADER_BYTES);
  localparam logic [2:0] LANE_LAST = 3'(LANE_BYTES - 1);

  logic [7:0]        hist_mem [WIN_BYTES];

  logic [LEN_W-1:0]  out_len_r;
  logic [HDR_W-1:0]  hdr_left_r;
  logic [7:0]        flag_r;
  logic [3:0]        flags_left_r;
  logic [1:0]        phase_r;
  logic [3:0]        nibble_r;
  logic [WIN_AW-1:0] dist_r;
  logic [LEN_W-1:0]  produced_r;
  logic              finished_r;
  logic [RUN_W-1:0]  copy_left_r;
  logic [7:0]        lit_r;
  logic [WIN_AW-1:0] wp_r;
  logic [WIN_AW:0]   fill_r;
  logic [7:0]        last_byte_r;
  logic [7:0]        rd_data_r;
  logic              rd_valid_r;
  logic [WORD_W-1:0] pack_r;
  logic [2:0]        pack_cnt_r;
  logic              out_valid_r;
  logic [WORD_W-1:0] out_bytes_r;
  logic [CNT_W-1:0]  out_cnt_r;
  logic              out_last_r;
  logic              out_done_r;

  // Parser next state for the byte on the input.
  logic [HDR_W-1:0]  e_hdr;
  logic [3:0]        e_flags;
  logic [1:0]        e_phase;
  logic [LEN_W-1:0]  e_prod;
  logic              e_fin;
  logic [7:0]        e_flag;
  logic              stop;
  logic              use_flag;
  logic              act_lit;
  logic              act_copy;
  logic [RUN_W-1:0]  run_len;
  logic [LEN_W-1:0]  room;
  logic [RUN_W-1:0]  copy_len;
  logic [HDR_W-1:0]  hdr_nxt;
  logic [3:0]        flags_nxt;
  logic [1:0]        phase_nxt;
  logic [7:0]        flag_nxt;
  logic [3:0]        nibble_nxt;
  logic [WIN_AW-1:0] dist_nxt;

  always_comb begin
    e_hdr      = start_stream ? HDR_RESET : hdr_left_r;
    e_flags    = start_stream ? 4'd0 : flags_left_r;
    e_phase    = start_stream ? PH_TOKEN : phase_r;
    e_prod     = start_stream ? '0 : produced_r;
    e_fin      = start_stream ? 1'b0 : finished_r;
    e_flag     = start_stream ? 8'd0 : flag_r;
    stop       = e_fin || (e_prod >= out_len_r);
    hdr_nxt    = e_hdr;
    flags_nxt  = e_flags;
    phase_nxt  = e_phase;
    flag_nxt   = e_flag;
    nibble_nxt = nibble_r;
    dist_nxt   = dist_r;
    use_flag   = 1'b0;
    act_lit    = 1'b0;
    act_copy   = 1'b0;
    run_len    = '0;
    if (stop) begin
      hdr_nxt = e_hdr;
    end else if (e_hdr != '0) begin
      hdr_nxt = e_hdr - HDR_W'(1);
    end else begin
      case (e_phase)
        PH_DIST_LO: begin
          dist_nxt = {dist_r[WIN_AW-1:8], in_byte};
          if (nibble_r == 4'd0) begin
            phase_nxt = PH_EXTRA;
          end else begin
            phase_nxt = PH_TOKEN;
            act_copy  = 1'b1;
            use_flag  = 1'b1;
            run_len   = {5'd0, nibble_r} + 9'd2;
          end
        end
        PH_EXTRA: begin
          phase_nxt = PH_TOKEN;
          act_copy  = 1'b1;
          use_flag  = 1'b1;
          run_len   = {1'b0, in_byte} + 9'd18;
        end
        default: begin
          phase_nxt = PH_TOKEN;
          if (e_flags == 4'd0) begin
            flag_nxt  = in_byte;
            flags_nxt = 4'd8;
          end else if (e_flag[7]) begin
            act_lit  = 1'b1;
            use_flag = 1'b1;
          end else begin
            nibble_nxt = in_byte[7:4];
            dist_nxt   = {in_byte[3:0], 8'd0};
            phase_nxt  = PH_DIST_LO;
          end
        end
      endcase
    end
    if (use_flag) begin
      flag_nxt  = {flag_nxt[6:0], 1'b0};
      flags_nxt = (flags_nxt != 4'd0) ? flags_nxt - 4'd1 : 4'd0;
    end
    // A reference never runs past the configured length.
    room     = out_len_r - e_prod;
    copy_len = (room < {{(LEN_W-RUN_W){1'b0}}, run_len}) ? room[RUN_W-1:0] : run_len;
  end

  // Byte write path.
  logic [7:0]        put_byte;
  logic              put_last;
  logic              emit;
  logic [WORD_W-1:0] merged;
  logic [WIN_AW-1:0] wp_nxt;
  logic [WIN_AW-1:0] rd_addr;
  logic              put_done;

  always_comb begin
    if (cmd.lit) begin
      put_byte = lit_r;
    end else if (dist_r == '0) begin
      put_byte = last_byte_r;
    end else begin
      put_byte = rd_valid_r ? rd_data_r : 8'd0;
    end
    put_last = cmd.lit || (copy_left_r == 9'd1);
    emit     = put_last || (pack_cnt_r == LANE_LAST);
    merged   = pack_r | ({{(WORD_W-8){1'b0}}, put_byte} << {pack_cnt_r, 3'b000});
    put_done = put_last && ((produced_r + 32'd1) >= out_len_r);
    wp_nxt   = cmd.put ? wp_r + WIN_AW'(1) : wp_r;
    // Address of the source byte for the write after this edge.
    rd_addr  = wp_nxt - dist_r - WIN_AW'(1);
  end

  assign sts.act_lit   = act_lit;
  assign sts.act_copy  = act_copy;
  assign sts.copy_last = (copy_left_r == 9'd1);
  assign sts.pack_room = (pack_cnt_r != LANE_LAST);
  assign sts.out_free  = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.put) begin
      hist_mem[wp_r] <= put_byte;
    end
    rd_data_r <= hist_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_len_r    <= '0;
      hdr_left_r   <= HDR_RESET;
      flag_r       <= '0;
      flags_left_r <= '0;
      phase_r      <= PH_TOKEN;
      nibble_r     <= '0;
      dist_r       <= '0;
      produced_r   <= '0;
      finished_r   <= 1'b0;
      copy_left_r  <= '0;
      wp_r         <= '0;
      fill_r       <= '0;
      last_byte_r  <= '0;
      rd_valid_r   <= 1'b0;
      pack_r       <= '0;
      pack_cnt_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        out_len_r <= cfg_wr_data;
      end
      // Entries below the fill count, or all once it saturates, hold data.
      rd_valid_r <= fill_r[WIN_AW] || (rd_addr < fill_r[WIN_AW-1:0]);
      if (cmd.take) begin
        hdr_left_r   <= hdr_nxt;
        flag_r       <= flag_nxt;
        flags_left_r <= flags_nxt;
        phase_r      <= phase_nxt;
        nibble_r     <= nibble_nxt;
        dist_r       <= dist_nxt;
        produced_r   <= e_prod;
        finished_r   <= stop;
        copy_left_r  <= copy_len;
      end
      if (cmd.put) begin
        wp_r        <= wp_nxt;
        last_byte_r <= put_byte;
        produced_r  <= produced_r + 32'd1;
        if (!fill_r[WIN_AW]) begin
          fill_r <= fill_r + (WIN_AW+1)'(1);
        end
        if (!cmd.lit) begin
          copy_left_r <= copy_left_r - RUN_W'(1);
        end
        if (put_last) begin
          finished_r <= put_done;
        end
        if (emit) begin
          pack_r     <= '0;
          pack_cnt_r <= '0;
        end else begin
          pack_r     <= merged;
          pack_cnt_r <= pack_cnt_r + 3'd1;
        end
      end
      if (cmd.put && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      lit_r <= in_byte;
    end
    if (cmd.put && emit) begin
      out_bytes_r <= merged;
      out_cnt_r   <= {1'b0, pack_cnt_r} + 4'd1;
      out_last_r  <= put_last;
      out_done_r  <= put_done;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_bytes  = out_bytes_r;
  assign byte_count = out_cnt_r;
  assign out_last   = out_last_r;
  assign out_done   = out_done_r;

endmodule

/* hdl/lz_window_byte_decoder.sv */
// Byte-serial LZ window decoder for a Yaz0-style compressed stream.
// Input: in_tdata carries one compressed byte; in_tuser marks the first header
// byte of a new stream and restarts the parser. The first HEADER_BYTES bytes
// are skipped, then a flag byte precedes every eight tokens (literal or
// back-reference into a 4096-byte history). Output: each transaction carries
// up to LANE_BYTES decoded bytes, first byte lowest; tlast marks the final
// transaction caused by one input byte and tuser says the configured length
// has now been reached. cfg_wr_en/cfg_wr_data set that length.
// Sequencing: a byte that decodes to nothing is taken in the idle state; a literal
// waits in a literal state until the output register is free. A back-reference
// passes a wait state for the history read, then writes the copied bytes as the
// history memory delivers one source byte per cycle, unless a word must leave while
// the output register is full; transactions leave every LANE_BYTES bytes and at run end.
// Reset clears the control state and presents the history as all zeros via a
// fill count, so no clearing pass is needed. A result waiting in the output
// register does not block input; if the receiver stalls, decoding halts only
// when the next packed word must be emitted, and resumes once it is taken.
// Depends on lzwbd_pkg, lzwbd_ctrl, lzwbd_datapath and the assertion macros.
`include "lz_window_byte_decoder_macros.svh"

module lz_window_byte_decoder #(
  parameter int HEADER_BYTES = 16,
  parameter int LANE_BYTES   = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration: output_length.
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  // Compressed input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  input  logic [0:0]  in_tuser,   // [0] start_stream
  // Decoded output stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [63:0] out_bytes, [67:64] byte_count, rest zero
  output logic        out_tlast,  // last_of_run
  output logic [0:0]  out_tuser   // [0] stream_done
);
  import lzwbd_pkg::*;

  cmd_t              cmd;
  sts_t              sts;
  logic [WORD_W-1:0] out_bytes;
  logic [CNT_W-1:0]  byte_count;
  logic              out_done;

  // The controller only sequences; every parser decision lives in the datapath.
  lzwbd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lzwbd_datapath #(
    .HEADER_BYTES (HEADER_BYTES),
    .LANE_BYTES   (LANE_BYTES)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_byte      (in_tdata),
    .start_stream (in_tuser[0]),
    .cmd          (cmd),
    .sts          (sts),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_bytes    (out_bytes),
    .byte_count   (byte_count),
    .out_last     (out_tlast),
    .out_done     (out_done)
  );

  assign out_tdata = {4'd0, byte_count, out_bytes};
  assign out_tuser = out_done;

  // Completion is only ever reported on the final transaction of an input byte.
  `LZWBD_ASSERT_IMP(a_done_is_last, out_tvalid && out_tuser[0], out_tlast)
  // No input byte is taken while decoded bytes are being written.
  `LZWBD_ASSERT_IMP(a_no_take_during_put, cmd.take, !cmd.put)
  // A byte that completes a back-reference holds off the next input.
  `LZWBD_ASSERT_NXT(a_copy_blocks_input, cmd.take && sts.act_copy, !in_tready)
  // Every result carries between one and LANE_BYTES bytes.
  `LZWBD_ASSERT_IMP(a_count_range, out_tvalid, (byte_count != 4'd0) && (byte_count <= 4'(LANE_BYTES)))

endmodule

/* tb/sv/tb_lz_window_byte_decoder.sv */
// Self-checking testbench for the byte-serial LZ window decoder (lz_window_byte_decoder).
// It predicts every packed output word from its own copy of the decoder state.
// Depends on lzwbd_pkg and the RTL of the decoder; it reads no files.
`timescale 1ns / 1ps

module tb_lz_window_byte_decoder;
  import lzwbd_pkg::*;

  // The header length matches the default parameter of the block.
  localparam int HDR_LEN     = 16;
  localparam int WORD_BYTES  = 8;
  // The quiet time after the last word must cover the longest back-reference, 273 bytes.
  localparam int SETTLE      = 300;
  localparam int HOLD_CYCLES = 800;
  localparam int RAND_ITEMS  = 380;
  localparam int CYCLE_LIMIT = 1000000;

  // One input transaction: a compressed byte and its stream-start flag.
  typedef struct packed {
    logic [7:0] value;
    logic       start;
  } comp_byte_t;

  // One output transaction as it should appear on the result channel.
  typedef struct packed {
    logic [63:0] bytes;
    logic [3:0]  count;
    logic        last;
    logic        done;
  } packed_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [31:0] cfg_wr_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic [0:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;
  logic        out_tlast;
  logic [0:0]  out_tuser;

  lz_window_byte_decoder u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  // Free-running 2 ns clock.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Bytes waiting to be offered, and packed words waiting to be seen.
  comp_byte_t   pending_bytes[$];
  packed_word_t words_due[$];

  // Traffic shaping. While calm is set neither side idles. A hold request
  // makes the receiver drop tready while it counts hold_left down from HOLD_CYCLES.
  bit calm = 1'b0;
  bit hold_req = 1'b0;
  int hold_left = 0;

  int n_pushed = 0;
  int n_taken = 0;
  int n_words = 0;
  int n_mismatch = 0;
  int n_settings = 0;
  int n_cycles = 0;

  // ---------------------------------------------------------------------
  // Decoder state as the testbench predicts it. It mirrors the block's
  // state: history window, write pointer, header and flag counters, the
  // token parse phase and the fields of a half-read back-reference.
  // ---------------------------------------------------------------------
  logic [7:0]  win_mem[0:4095];
  logic [11:0] win_ptr;
  logic [4:0]  hdr_left;
  logic [7:0]  flag_bits;
  logic [3:0]  flags_left;
  logic [1:0]  phase;
  logic [3:0]  len_nibble;
  logic [11:0] dist_field;
  logic [31:0] produced;
  logic [31:0] target_len;
  bit          stream_over;
  logic [7:0]  decoded_run[$];

  // A stream start clears the parser but keeps the window and its pointer.
  task automatic restart_parser();
    hdr_left    = 5'(HDR_LEN);
    flag_bits   = '0;
    flags_left  = '0;
    phase       = PH_TOKEN;
    len_nibble  = '0;
    dist_field  = '0;
    produced    = '0;
    stream_over = 1'b0;
  endtask

  task automatic clear_model();
    foreach (win_mem[i]) win_mem[i] = 8'h00;
    win_ptr    = '0;
    target_len = '0;
    restart_parser();
  endtask

  // Every decoded byte goes into the window and into the current run.
  task automatic emit_byte(input logic [7:0] b);
    win_mem[win_ptr] = b;
    win_ptr          = win_ptr + 12'd1;
    decoded_run.push_back(b);
    produced         = produced + 32'd1;
  endtask

  // The copy is done byte by byte, so a short distance repeats bytes that
  // the same reference has just written. It stops at the configured length.
  task automatic copy_from_window(input int unsigned len);
    logic [31:0] room;
    logic [11:0] src;
    int unsigned n;
    room = target_len - produced;
    n = len;
    if (n > room) n = room;
    for (int unsigned i = 0; i < n; i++) begin
      src = win_ptr - dist_field - 12'd1;
      emit_byte(win_mem[src]);
    end
  endtask

  task automatic consume_flag();
    flag_bits = flag_bits << 1;
    if (flags_left > 0) flags_left = flags_left - 4'd1;
  endtask

  // Decodes one accepted byte and queues the words it must produce.
  task automatic decode_byte(input logic [7:0] b, input logic start);
    packed_word_t w;
    int cnt;
    decoded_run.delete();
    if (start) restart_parser();
    // Once the length is reached, nothing comes out until the next start.
    if (stream_over || produced >= target_len) begin
      stream_over = 1'b1;
      return;
    end
    if (hdr_left > 0) begin
      hdr_left = hdr_left - 5'd1;
      return;
    end
    case (phase)
      PH_DIST_LO: begin
        dist_field = {dist_field[11:8], b};
        if (len_nibble == 4'd0) begin
          phase = PH_EXTRA;
        end else begin
          phase = PH_TOKEN;
          copy_from_window(int'(len_nibble) + 2);
          consume_flag();
        end
      end
      PH_EXTRA: begin
        phase = PH_TOKEN;
        copy_from_window(int'(b) + 18);
        consume_flag();
      end
      default: begin
        // The unused phase code falls through here like the token phase.
        phase = PH_TOKEN;
        if (flags_left == 4'd0) begin
          flag_bits  = b;
          flags_left = 4'd8;
        end else if (flag_bits[7]) begin
          emit_byte(b);
          consume_flag();
        end else begin
          len_nibble = b[7:4];
          dist_field = {b[3:0], 8'h00};
          phase      = PH_DIST_LO;
        end
      end
    endcase
    if (produced >= target_len) stream_over = 1'b1;
    // Pack the run into words of up to eight bytes, first byte lowest.
    for (int i = 0; i < decoded_run.size(); i += WORD_BYTES) begin
      cnt = decoded_run.size() - i;
      if (cnt > WORD_BYTES) cnt = WORD_BYTES;
      w.bytes = '0;
      for (int j = 0; j < cnt; j++) w.bytes[8*j +: 8] = decoded_run[i + j];
      w.count = 4'(cnt);
      w.last  = (i + WORD_BYTES >= decoded_run.size());
      w.done  = w.last && stream_over;
      words_due.push_back(w);
    end
  endtask

  // ---------------------------------------------------------------------
  // Input driver. On each rising edge it first books the transaction that
  // completed at this edge, then offers the next byte when the slot is
  // free. tvalid is never withdrawn before its transaction completes.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    comp_byte_t item;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= '0;
    end else begin
      if (in_tvalid && in_tready) begin
        decode_byte(in_tdata, in_tuser[0]);
        n_taken++;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_bytes.size() > 0 && (calm || $urandom_range(0, 99) >= 24)) begin
          item = pending_bytes.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= item.value;
          in_tuser  <= item.start;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic report_mismatch(input string what, input packed_word_t w);
    n_mismatch++;
    if (n_mismatch <= 10) begin
      $display("MISMATCH (%s) at cycle %0d: expected bytes=%h count=%0d last=%0b done=%0b",
               what, n_cycles, w.bytes, w.count, w.last, w.done);
      $display("  actual tdata=%h tlast=%0b tuser=%0b", out_tdata, out_tlast, out_tuser);
    end
  endtask

  // ---------------------------------------------------------------------
  // Output monitor. Each completed result transaction is compared with the
  // oldest predicted word. The receiver idles at random, except during a
  // long hold, which it counts down itself while the sender keeps going.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    packed_word_t w;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        n_words++;
        if (words_due.size() == 0) begin
          w = '0;
          report_mismatch("no word was due", w);
        end else begin
          w = words_due.pop_front();
          if (out_tdata[63:0] !== w.bytes)
            report_mismatch("data bytes", w);
          else if (out_tdata[71:64] !== {4'b0000, w.count})
            report_mismatch("byte count", w);
          else if (out_tlast !== w.last)
            report_mismatch("last of run", w);
          else if (out_tuser[0] !== w.done)
            report_mismatch("stream done", w);
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
        out_tready <= 1'b0;
      end else begin
        out_tready <= calm || ($urandom_range(0, 99) >= 24);
      end
    end
  end

  // Watchdog: a hung block ends the run as a failure.
  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d words still due", n_cycles, words_due.size());
      $display("[lz_window_byte_decoder] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------
  task automatic push_byte(input logic [7:0] b, input logic start);
    comp_byte_t it;
    it.value = b;
    it.start = start;
    pending_bytes.push_back(it);
    n_pushed++;
  endtask

  task automatic push_header(input bit with_start);
    for (int i = 0; i < HDR_LEN; i++)
      push_byte(8'($urandom), with_start && (i == 0));
  endtask

  // A back-reference with a random distance, mostly short so that it
  // reads freshly decoded bytes, sometimes far or the full window.
  task automatic push_reference(input bit long_refs);
    logic [11:0] d;
    int r;
    bit extended;
    r = $urandom_range(0, 9);
    if (r < 6) d = 12'($urandom_range(0, 15));
    else if (r < 9) d = 12'($urandom_range(0, 4095));
    else d = 12'hfff;
    extended = long_refs ? ($urandom_range(0, 1) == 1) : ($urandom_range(0, 9) < 3);
    if (extended) begin
      push_byte({4'h0, d[11:8]}, 1'b0);
      push_byte(d[7:0], 1'b0);
      if (long_refs) push_byte(8'($urandom_range(128, 255)), 1'b0);
      else if ($urandom_range(0, 4) == 0) push_byte(8'($urandom), 1'b0);
      else push_byte(8'($urandom_range(0, 20)), 1'b0);
    end else begin
      push_byte({4'($urandom_range(1, 15)), d[11:8]}, 1'b0);
      push_byte(d[7:0], 1'b0);
    end
  endtask

  // Flag byte followed by eight tokens, most significant flag first.
  task automatic push_groups(input int n_groups, input bit long_refs);
    logic [7:0] flags;
    for (int g = 0; g < n_groups; g++) begin
      flags = 8'($urandom);
      push_byte(flags, 1'b0);
      for (int k = 7; k >= 0; k--) begin
        if (flags[k]) push_byte(8'($urandom), 1'b0);
        else push_reference(long_refs);
      end
    end
  endtask

  // A write takes effect at the edge where the enable is high. It is only
  // issued while the block is idle, so the model can follow at once.
  task automatic write_length(input logic [31:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    target_len = v;
    n_settings++;
  endtask

  // Waits until every byte is taken and every predicted word has arrived,
  // then lets the longest back-reference time run out.
  task automatic drain();
    do @(posedge clk);
    while (pending_bytes.size() != 0 || in_tvalid || words_due.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------
  initial begin
    int ph;
    int r;
    clear_model();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. The first stream comes without a start flag, since the
    // block starts out as if a stream had just begun. Header bytes take
    // both extreme values.
    write_length(32'hffff_ffff);
    for (int i = 0; i < HDR_LEN; i++) push_byte((i % 2 == 1) ? 8'hff : 8'h00, 1'b0);
    // Flags 0101_0...: reference, literal, reference, literal, reference.
    push_byte(8'h50, 1'b0);
    // Full-window distance with the longest extended length: reads the
    // entry about to be overwritten, still zero after reset.
    push_byte(8'h0f, 1'b0);
    push_byte(8'hff, 1'b0);
    push_byte(8'hff, 1'b0);
    push_byte(8'hff, 1'b0);
    // Distance one, length seventeen: an overlapping copy of the last byte.
    push_byte(8'hf0, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    // Shortest reference, distance two.
    push_byte(8'h10, 1'b0);
    push_byte(8'h01, 1'b0);
    drain();

    // Lowering the length below what was already produced ends the stream
    // at once; a further byte must give nothing.
    write_length(32'd200);
    push_byte(8'h80, 1'b0);
    drain();

    // A length of zero: the stream is complete as soon as it starts.
    write_length(32'd0);
    push_byte(8'h5a, 1'b1);
    push_byte(8'ha5, 1'b0);
    push_byte(8'h00, 1'b0);
    drain();

    // Random part. Most phases are well-formed streams with random tokens;
    // some continue the previous stream under a new length, and some are
    // noise with stray stream starts.
    ph = 0;
    while (n_pushed < RAND_ITEMS - 25) begin
      r = $urandom_range(0, 9);
      if (ph == 1) write_length(32'd1);
      else if (r == 0) write_length(32'hffff_ffff);
      else if (r == 1) write_length(32'($urandom));
      else write_length(32'($urandom_range(8, 400)));

      calm = (ph == 3);
      r = $urandom_range(0, 9);
      if (ph == 0) begin
        // Long references while the receiver holds off: the output fills
        // up and the block must stall its input.
        push_header(1'b1);
        push_groups(2, 1'b1);
        hold_req = 1'b1;
      end else if (r == 0) begin
        for (int i = 0; i < 20; i++)
          push_byte(8'($urandom), $urandom_range(0, 9) == 0);
      end else if (r == 1) begin
        push_groups($urandom_range(1, 3), 1'b0);
      end else begin
        push_header(1'b1);
        push_groups($urandom_range(1, 4), 1'b0);
      end
      drain();
      calm = 1'b0;
      ph++;
    end

    $display("Run covered %0d compressed bytes over %0d length settings, %0d words checked.",
             n_taken, n_settings, n_words);
    $display("Included: restarts, length cut-offs, full-window and overlapping copies, a long stall.");
    if (n_mismatch == 0 && words_due.size() == 0) begin
      $display("[lz_window_byte_decoder] OK");
    end else begin
      $display("%0d mismatches, %0d words never arrived", n_mismatch, words_due.size());
      $display("[lz_window_byte_decoder] ERROR");
    end
    $finish;
  end

endmodule
